@@ rtl/core/ospct_pkg.sv @@
// Shared types and constants of the one-shot and periodic compare timer.
package ospct_pkg;

	localparam int TIME_W  = 64;
	localparam int RES_W   = 32;
	localparam int CMD_W   = 3;
	localparam int DIGIT_W = 8;
	localparam int NDIG    = TIME_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(NDIG);
	localparam int MOD_CNT_W = $clog2(TIME_W);

	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START_AT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START_AFTER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START_REP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REP_FIRE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CANCEL      = 3'd5;
	localparam logic [CMD_W-1:0] CMD_JUMP        = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [TIME_W-1:0] now_time;
		logic signed [TIME_W-1:0] amount;
	} in_beat_t;

	typedef struct packed {
		logic                     fired;
		logic                     armed;
		logic signed [TIME_W-1:0] next_trigger;
	} out_beat_t;

	// Request to the digit-serial adder
	typedef struct packed {
		logic              start;
		logic              sub;
		logic              sat;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} add_req_t;

	typedef struct packed {
		logic              done;
		logic              lt;
		logic [TIME_W-1:0] result;
	} add_rsp_t;

	// Request to the iterative modulo unit
	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] num;
		logic [TIME_W-1:0] den;
	} mod_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] rem;
	} mod_rsp_t;

endpackage

@@ rtl/core/ospct_serial_add.sv @@
// Digit-serial signed adder/subtractor with optional saturation and signed compare.
module ospct_serial_add (
	input  logic                clk,
	input  logic                arst_n,
	input  ospct_pkg::add_req_t req,
	output ospct_pkg::add_rsp_t rsp
);
	import ospct_pkg::*;

	localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NDIG - 1);

	logic [TIME_W-1:0]    a_q, b_q, sum_q, result_q;
	logic                 carry_q, a_sign_q, b_sign_q, sat_q, lt_q;
	logic                 busy_q, done_q;
	logic [DIG_CNT_W-1:0] cnt_q;

	logic [DIGIT_W:0]     dsum;
	logic [TIME_W-1:0]    full;
	logic                 ovf;
	logic [TIME_W-1:0]    b_load;

	// One digit of the sum, plus the completed word on the last digit
	always_comb begin
		dsum = {1'b0, a_q[DIGIT_W-1:0]} + {1'b0, b_q[DIGIT_W-1:0]}
			+ {{DIGIT_W{1'b0}}, carry_q};
		full = {dsum[DIGIT_W-1:0], sum_q[TIME_W-1:DIGIT_W]};
		ovf  = (a_sign_q == b_sign_q) && (full[TIME_W-1] != a_sign_q);
		b_load = req.sub ? ~req.b : req.b;
	end

	// Control: load on start, advance one digit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIG_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift operands down, shift sum digits in from the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q      <= req.a;
			b_q      <= b_load;
			carry_q  <= req.sub;
			a_sign_q <= req.a[TIME_W-1];
			b_sign_q <= b_load[TIME_W-1];
			sat_q    <= req.sat;
		end else if (busy_q) begin
			a_q     <= a_q >> DIGIT_W;
			b_q     <= b_q >> DIGIT_W;
			carry_q <= dsum[DIGIT_W];
			sum_q   <= full;
			if (cnt_q == DIG_LAST) begin
				lt_q <= full[TIME_W-1] ^ ovf;
				if (sat_q && ovf)
					result_q <= a_sign_q ? TIME_MIN : TIME_MAX;
				else
					result_q <= full;
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.lt     = lt_q;
	assign rsp.result = result_q;

endmodule

@@ rtl/core/ospct_mod.sv @@
// Iterative restoring modulo unit, one remainder bit per cycle.
module ospct_mod (
	input  logic                clk,
	input  logic                arst_n,
	input  ospct_pkg::mod_req_t req,
	output ospct_pkg::mod_rsp_t rsp
);
	import ospct_pkg::*;

	localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(TIME_W - 1);

	logic [TIME_W-1:0]    num_q, den_q, rem_q;
	logic                 busy_q, done_q;
	logic [MOD_CNT_W-1:0] cnt_q;

	logic [TIME_W:0]      shifted;
	logic [TIME_W+1:0]    trial;
	logic [TIME_W-1:0]    rem_next;

	// Shift in the next dividend bit and try one subtract
	always_comb begin
		shifted  = {rem_q, num_q[TIME_W-1]};
		trial    = {1'b0, shifted} - {2'b00, den_q};
		rem_next = trial[TIME_W+1] ? shifted[TIME_W-1:0] : trial[TIME_W-1:0];
	end

	// Control: count the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: a zero divisor leaves a zero remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (cnt_q == MOD_LAST && den_q == '0)
				rem_q <= '0;
			else
				rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ rtl/core/one_shot_periodic_compare_timer_core.sv @@
// Top level of the one-shot and periodic compare timer: sequencer and timer state.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries a command, the current time
//   and one time operand. Every accepted beat yields exactly one output beat
//   (out_valid/out_stall/out_data) with the fired flag, the armed flag and the
//   pending trigger time after the command.
//   cfg_we/cfg_data write the 32-bit time base resolution; write only while idle.
// Sequencing:
//   One item at a time. Sums and compares run through one digit-serial adder,
//   8 bits a cycle. Cancel, unused codes and a tick on a disarmed timer skip
//   the adder; starts and jumps take 2 to 3 passes; a tick that fires a
//   repeating timer takes five passes plus one run of the modulo unit.
// Reset:
//   arst_n clears the timer (disarmed, one-shot, trigger and period zero) and
//   sets the resolution to 1. No output beat is pending.
// Stall:
//   The result sits in an output register; a new input beat is taken while it
//   waits. A finished item holds in the sequencer until the register frees up.
module one_shot_periodic_compare_timer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ospct_pkg::in_beat_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ospct_pkg::out_beat_t                out_data,
	input  logic                                cfg_we,
	input  logic [ospct_pkg::RES_W-1:0]         cfg_data
);
	import ospct_pkg::*;

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_MOD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Adder pass being waited on
	localparam logic [3:0] SP_ALIM = 4'd0;
	localparam logic [3:0] SP_ACMP = 4'd1;
	localparam logic [3:0] SP_SUM1 = 4'd2;
	localparam logic [3:0] SP_ARM  = 4'd3;
	localparam logic [3:0] SP_JMP  = 4'd4;
	localparam logic [3:0] SP_JEND = 4'd5;
	localparam logic [3:0] SP_TCMP = 4'd6;
	localparam logic [3:0] SP_GAP  = 4'd7;
	localparam logic [3:0] SP_MAG  = 4'd8;
	localparam logic [3:0] SP_BASE = 4'd9;
	localparam logic [3:0] SP_REP  = 4'd10;

	logic [1:0]        state_q;
	logic [3:0]        step_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [TIME_W-1:0] now_q, amt_q, gap_q;
	logic              fired_q;

	logic              armed_q, rep_q;
	logic [TIME_W-1:0] trig_q, period_q;
	logic [RES_W-1:0]  res_q;

	logic              out_valid_q;
	out_beat_t         out_q;

	add_req_t          add_req_q;
	add_rsp_t          add_rsp;
	mod_req_t          mod_req_q;
	mod_rsp_t          mod_rsp;

	logic [TIME_W-1:0] res_ext;
	logic              cmd_rep;

	function automatic add_req_t issue(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b, input logic sub, input logic sat);
		add_req_t r;
		r.start = 1'b1;
		r.sub   = sub;
		r.sat   = sat;
		r.a     = a;
		r.b     = b;
		return r;
	endfunction

	assign res_ext = {{(TIME_W-RES_W){1'b0}}, res_q};
	assign cmd_rep = (cmd_q == CMD_START_REP) || (cmd_q == CMD_REP_FIRE);

	ospct_serial_add u_add (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (add_req_q),
		.rsp    (add_rsp)
	);

	ospct_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req_q),
		.rsp    (mod_rsp)
	);

	// Sequencer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			armed_q         <= 1'b0;
			rep_q           <= 1'b0;
			trig_q          <= '0;
			period_q        <= '0;
			res_q           <= RES_W'(1);
			out_valid_q     <= 1'b0;
			add_req_q.start <= 1'b0;
			mod_req_q.start <= 1'b0;
		end else begin
			add_req_q.start <= 1'b0;
			mod_req_q.start <= 1'b0;
			if (cfg_we)
				res_q <= cfg_data;
			// drop the output beat once taken
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_data.command;
						now_q   <= in_data.now_time;
						amt_q   <= in_data.amount;
						fired_q <= 1'b0;
						state_q <= ST_ADD;
						case (in_data.command)
							CMD_TICK: begin
								if (armed_q) begin
									add_req_q <= issue(in_data.now_time, trig_q, 1'b1, 1'b0);
									step_q    <= SP_TCMP;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_START_AT: begin
								add_req_q <= issue(TIME_MAX, res_ext, 1'b1, 1'b0);
								step_q    <= SP_ALIM;
							end
							CMD_START_AFTER, CMD_START_REP, CMD_REP_FIRE: begin
								add_req_q <= issue(in_data.now_time, in_data.amount, 1'b0, 1'b1);
								step_q    <= SP_SUM1;
							end
							CMD_CANCEL: begin
								armed_q <= 1'b0;
								trig_q  <= '0;
								state_q <= ST_DONE;
							end
							CMD_JUMP: begin
								add_req_q <= issue(in_data.amount, in_data.now_time, 1'b1, 1'b1);
								step_q    <= SP_JMP;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (add_rsp.done) begin
						case (step_q)
							SP_ALIM: begin
								add_req_q <= issue(amt_q, add_rsp.result, 1'b1, 1'b0);
								step_q    <= SP_ACMP;
							end
							SP_ACMP: begin
								// below the limit: arm, otherwise cancel
								if (add_rsp.lt) begin
									add_req_q <= issue(amt_q, res_ext, 1'b0, 1'b1);
									step_q    <= SP_ARM;
								end else begin
									armed_q <= 1'b0;
									trig_q  <= '0;
									state_q <= ST_DONE;
								end
							end
							SP_SUM1: begin
								add_req_q <= issue(add_rsp.result, res_ext, 1'b0, 1'b1);
								step_q    <= SP_ARM;
							end
							SP_ARM: begin
								trig_q  <= add_rsp.result;
								armed_q <= 1'b1;
								rep_q   <= cmd_rep;
								if (cmd_rep)
									period_q <= amt_q;
								fired_q <= (cmd_q == CMD_REP_FIRE);
								state_q <= ST_DONE;
							end
							SP_JMP: begin
								add_req_q <= issue(trig_q, add_rsp.result, 1'b0, 1'b1);
								step_q    <= SP_JEND;
							end
							SP_JEND: begin
								trig_q  <= add_rsp.result;
								state_q <= ST_DONE;
							end
							SP_TCMP: begin
								// now before trigger: nothing to do
								if (add_rsp.lt) begin
									state_q <= ST_DONE;
								end else begin
									fired_q <= 1'b1;
									if (!rep_q) begin
										armed_q <= 1'b0;
										trig_q  <= '0;
										state_q <= ST_DONE;
									end else begin
										add_req_q <= issue(now_q, trig_q, 1'b1, 1'b0);
										step_q    <= SP_GAP;
									end
								end
							end
							SP_GAP: begin
								gap_q     <= add_rsp.result;
								add_req_q <= issue('0, period_q, 1'b1, 1'b0);
								step_q    <= SP_MAG;
							end
							SP_MAG: begin
								mod_req_q.start <= 1'b1;
								mod_req_q.num   <= gap_q;
								mod_req_q.den   <= period_q[TIME_W-1] ? add_rsp.result : period_q;
								state_q         <= ST_MOD;
							end
							SP_BASE: begin
								add_req_q <= issue(add_rsp.result, period_q, 1'b0, 1'b1);
								step_q    <= SP_REP;
							end
							SP_REP: begin
								trig_q  <= add_rsp.result;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_MOD: begin
					// skip the missed periods: base = now - gap mod period
					if (mod_rsp.done) begin
						add_req_q <= issue(now_q, mod_rsp.rem, 1'b1, 1'b0);
						step_q    <= SP_BASE;
						state_q   <= ST_ADD;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_q.fired        <= fired_q;
						out_q.armed        <= armed_q;
						out_q.next_trigger <= trig_q;
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer took a beat without going busy");

	a_add_done_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		add_rsp.done |-> state_q == ST_ADD)
		else $error("adder finished while sequencer was not waiting on it");

	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> state_q == ST_MOD)
		else $error("modulo unit finished while sequencer was not waiting on it");
`endif

endmodule

@@ bench/timer_result_checker.sv @@
// Checker for the compare timer: watches both channels, predicts every result and compares.
module timer_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  ospct_pkg::in_beat_t         in_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  ospct_pkg::out_beat_t        out_data,
	input  logic                        cfg_we,
	input  logic [ospct_pkg::RES_W-1:0] cfg_data,
	output int                          mismatches,
	output int                          pending,
	output int                          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import ospct_pkg::*;

	// Predicted timer state and resolution register
	logic                     tmr_armed;
	logic                     tmr_repeat;
	logic signed [TIME_W-1:0] tmr_trigger;
	logic signed [TIME_W-1:0] tmr_period;
	logic [RES_W-1:0]         tmr_resolution;

	// Results still owed by the block, oldest first
	out_beat_t expected_timer_q[$];

	// Signed 64-bit sum and difference clamped at the type limits
	function automatic logic signed [TIME_W-1:0] sat_sum(
		input logic signed [TIME_W-1:0] a,
		input logic signed [TIME_W-1:0] b
	);
		logic [TIME_W:0] s;
		s = {a[TIME_W-1], a} + {b[TIME_W-1], b};
		if (s[TIME_W] != s[TIME_W-1])
			return s[TIME_W] ? TIME_MIN : TIME_MAX;
		return s[TIME_W-1:0];
	endfunction

	function automatic logic signed [TIME_W-1:0] sat_diff(
		input logic signed [TIME_W-1:0] a,
		input logic signed [TIME_W-1:0] b
	);
		logic [TIME_W:0] s;
		s = {a[TIME_W-1], a} - {b[TIME_W-1], b};
		if (s[TIME_W] != s[TIME_W-1])
			return s[TIME_W] ? TIME_MIN : TIME_MAX;
		return s[TIME_W-1:0];
	endfunction

	// Apply one command to the predicted timer and return the result beat it yields
	function automatic out_beat_t apply_timer_command(input in_beat_t cmd_beat);
		logic signed [TIME_W-1:0] now, amt, res, top, t, base;
		logic [TIME_W-1:0]        gap, mag, d;
		out_beat_t                r;
		now = cmd_beat.now_time;
		amt = cmd_beat.amount;
		res = {{(TIME_W-RES_W){1'b0}}, tmr_resolution};
		top = TIME_MAX;
		r.fired = 1'b0;
		case (cmd_beat.command)
			CMD_TICK: begin
				if (tmr_armed && now >= tmr_trigger) begin
					r.fired = 1'b1;
					if (tmr_repeat) begin
						// skip the whole periods that went by, then add one period
						t = (now > tmr_trigger) ? now : tmr_trigger;
						gap = t - tmr_trigger;
						mag = tmr_period[TIME_W-1] ? -tmr_period : tmr_period;
						d = (mag == '0) ? '0 : gap % mag;
						base = t - d;
						tmr_trigger = sat_sum(base, tmr_period);
					end else begin
						tmr_armed = 1'b0;
						tmr_trigger = '0;
					end
				end
			end
			CMD_START_AT: begin
				// too close to the top of the time range: cancel instead
				if (amt < top - res) begin
					tmr_trigger = amt + res;
					tmr_armed = 1'b1;
					tmr_repeat = 1'b0;
				end else begin
					tmr_armed = 1'b0;
					tmr_trigger = '0;
				end
			end
			CMD_START_AFTER: begin
				tmr_trigger = sat_sum(sat_sum(now, amt), res);
				tmr_armed = 1'b1;
				tmr_repeat = 1'b0;
			end
			CMD_START_REP, CMD_REP_FIRE: begin
				tmr_period = amt;
				tmr_trigger = sat_sum(sat_sum(now, amt), res);
				tmr_armed = 1'b1;
				tmr_repeat = 1'b1;
				r.fired = (cmd_beat.command == CMD_REP_FIRE);
			end
			CMD_CANCEL: begin
				tmr_armed = 1'b0;
				tmr_trigger = '0;
			end
			CMD_JUMP: begin
				// shift applies even while disarmed
				tmr_trigger = sat_sum(tmr_trigger, sat_diff(amt, now));
			end
			default: begin
			end
		endcase
		r.armed = tmr_armed;
		r.next_trigger = tmr_trigger;
		return r;
	endfunction

	// Print one line per mismatch (first few only) and count them all
	task automatic report_mismatch(input string what);
		if (mismatches < 30)
			$display("%0t ns: timer result mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Track config writes, predict accepted commands, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			tmr_armed = 1'b0;
			tmr_repeat = 1'b0;
			tmr_trigger = '0;
			tmr_period = '0;
			tmr_resolution = 1;
			expected_timer_q.delete();
			mismatches = 0;
			results_seen = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				tmr_resolution = cfg_data;
			if (in_valid && !in_stall)
				expected_timer_q.push_back(apply_timer_command(in_data));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_timer_q.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_timer_q.pop_front();
					if (out_data.fired !== want.fired)
						report_mismatch($sformatf("result %0d fired %b, expected %b",
							results_seen, out_data.fired, want.fired));
					if (out_data.armed !== want.armed)
						report_mismatch($sformatf("result %0d armed %b, expected %b",
							results_seen, out_data.armed, want.armed));
					if (out_data.next_trigger !== want.next_trigger)
						report_mismatch($sformatf("result %0d next_trigger %0d, expected %0d",
							results_seen, out_data.next_trigger, want.next_trigger));
				end
			end
			pending <= expected_timer_q.size();
		end
	end

endmodule

@@ bench/tb.sv @@
// Stimulus and verdict for the one-shot and periodic compare timer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ospct_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam longint T_MAX = longint'(TIME_MAX);
	localparam longint T_MIN = longint'(TIME_MIN);
	localparam int PHASE_ITEMS = 190;
	localparam int LONG_HOLD = 600;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_beat_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_beat_t        out_data;
	logic             cfg_we;
	logic [RES_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int results_seen;
	int items_sent = 0;
	int settings_used = 1;
	bit quiet = 0;
	bit hold_req = 0;
	longint res_now = 1;

	one_shot_periodic_compare_timer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	timer_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#9_600_000;
		$display("Some tests failed");
		$finish;
	end

	// Output side: random stall before each beat, one long hold-off on request
	initial begin
		int n;
		forever begin
			if (hold_req) begin
				hold_req = 0;
				n = LONG_HOLD;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 9);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic longint rand64();
		return longint'({$urandom(), $urandom()});
	endfunction

	function automatic longint spread(input int lo, input int hi);
		return longint'(lo) + longint'($urandom_range(0, hi - lo));
	endfunction

	// Offer one command beat and hold it until the block takes it
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input longint now, input longint amt);
		in_beat_t b;
		int gap;
		b.command = cmd;
		b.now_time = now;
		b.amount = amt;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Stop offering and wait until every owed result is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_resolution(input logic [RES_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		res_now = longint'(v);
		settings_used++;
	endtask

	// Time values biased toward the range limits and the start-at cutoff
	function automatic longint pick_time();
		case ($urandom_range(0, 7))
			0: return T_MAX;
			1: return T_MIN;
			2: return 0;
			3: return T_MAX - res_now - spread(0, 2);
			default: return rand64();
		endcase
	endfunction

	function automatic longint pick_base();
		case ($urandom_range(0, 5))
			0: return T_MIN + spread(0, 1000);
			1: return T_MAX - spread(0, 1000);
			2: return rand64();
			default: return rand64() >>> 24;
		endcase
	endfunction

	function automatic longint pick_span();
		case ($urandom_range(0, 15))
			0, 1: return 0;
			2, 3: return -spread(1, 50);
			4: return rand64();
			default: return spread(1, 300);
		endcase
	endfunction

	// One start followed by ticks that land around the expected trigger
	task automatic run_timer_scenario();
		longint clock_t, mark, span, mag, newt, now;
		int n;
		clock_t = pick_base();
		span = pick_span();
		mag = (span < 0) ? -span : span;
		mark = clock_t + span + res_now;
		case ($urandom_range(1, 4))
			1: begin
				mark = clock_t + spread(0, 300);
				send_beat(CMD_START_AT, clock_t, mark);
				mark = mark + res_now;
			end
			2: send_beat(CMD_START_AFTER, clock_t, span);
			3: send_beat(CMD_START_REP, clock_t, span);
			default: send_beat(CMD_REP_FIRE, clock_t, span);
		endcase
		n = $urandom_range(4, 14);
		repeat (n) begin
			case ($urandom_range(0, 19))
				0: send_beat(CMD_CANCEL, clock_t, rand64());
				1: begin
					newt = clock_t + spread(-500, 500);
					send_beat(CMD_JUMP, clock_t, newt);
					mark = mark + (newt - clock_t);
					clock_t = newt;
				end
				2: send_beat(CMD_TICK, rand64(), rand64());
				default: begin
					case ($urandom_range(0, 3))
						0: now = clock_t + spread(0, 50);
						1: now = mark + spread(-3, 3);
						2: now = mark + spread(0, 5) * mag + spread(0, 3);
						default: now = clock_t;
					endcase
					send_beat(CMD_TICK, now, rand64());
					clock_t = now;
					if (now >= mark)
						mark = now + span;
				end
			endcase
		end
	endtask

	// Range limits, every command, saturation, zero and negative periods
	task automatic run_directed();
		send_beat(CMD_TICK, 0, 0);
		send_beat(CMD_START_AT, 0, T_MAX);
		send_beat(CMD_START_AT, 0, T_MAX - 2);
		send_beat(CMD_START_AT, 0, T_MAX - 1);
		send_beat(CMD_START_AT, 0, T_MIN);
		send_beat(CMD_TICK, T_MIN, 0);
		send_beat(CMD_TICK, T_MIN + 1, 0);
		send_beat(CMD_START_AFTER, T_MAX, T_MAX);
		send_beat(CMD_TICK, T_MAX, 0);
		send_beat(CMD_START_AFTER, T_MIN, T_MIN);
		send_beat(CMD_START_REP, 100, 10);
		send_beat(CMD_TICK, 111, 0);
		send_beat(CMD_TICK, 200, 0);
		send_beat(CMD_REP_FIRE, 0, 0);
		send_beat(CMD_TICK, 50, 0);
		send_beat(CMD_TICK, 50, 0);
		send_beat(CMD_START_REP, 1000, -7);
		send_beat(CMD_TICK, 994, 0);
		send_beat(CMD_TICK, 994, 0);
		send_beat(CMD_START_REP, 0, T_MIN);
		send_beat(CMD_TICK, T_MAX, 0);
		send_beat(CMD_JUMP, T_MIN, T_MAX);
		send_beat(CMD_CANCEL, 0, 0);
		send_beat(CMD_JUMP, 0, -5);
		send_beat(CMD_UNUSED, T_MAX, T_MIN);
	endtask

	// Reset, directed beats, then random phases under several resolutions
	initial begin
		logic [RES_W-1:0] res_list[6];
		int phase_end;
		bit paused;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		res_list = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd7, 32'd0};
		res_list[3] = $urandom_range(2, 1000);
		res_list[5] = $urandom();
		foreach (res_list[p]) begin
			write_resolution(res_list[p]);
			// back up the output side while commands keep coming
			if (p == 1)
				hold_req = 1;
			phase_end = items_sent + PHASE_ITEMS;
			paused = 0;
			while (items_sent < phase_end) begin
				if (($urandom_range(0, 7) == 0))
					quiet = ~quiet;
				if (!paused && items_sent > phase_end - PHASE_ITEMS / 2) begin
					settle();
					paused = 1;
				end
				if ($urandom_range(0, 4) == 0)
					send_beat(CMD_W'($urandom_range(0, 7)), pick_time(), pick_time());
				else
					run_timer_scenario();
			end
		end

		settle();
		repeat (150) @(posedge clk);
		$display("Sent %0d timer commands, checked %0d results under %0d resolution settings,",
			items_sent, results_seen, settings_used);
		$display("including a long output hold-off and drained pauses between phases.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
